/* rtl/core/aq_pkg.sv */
`default_nettype none

package aq_pkg;

  localparam int FRAC_BITS  = 30;
  localparam int MANT_BITS  = 30;
  localparam int IN_W       = 32;
  localparam int WIDE_W     = 64;
  localparam int BX_W       = 36;
  localparam int Q_W        = 40;
  localparam int MAG_W      = MANT_BITS + 1;
  localparam int SUM_W      = 64;
  localparam int ROOT_STEPS = 32;
  localparam int ROOT_W     = 32;
  localparam int QUO_BITS   = FRAC_BITS + 1;
  localparam int REM_W      = 64;

  localparam logic signed [WIDE_W-1:0] HALF_FX = WIDE_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [Q_W-1:0]    ONE_Q   = Q_W'(64'd1 << FRAC_BITS);
  localparam logic signed [Q_W-1:0]    TRACE_MIN_Q =
    Q_W'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_e;

  typedef logic [2:0][IN_W-1:0] vec3_t;

endpackage

`default_nettype wire

/* rtl/core/axes_to_quaternion.sv */
// Throughput: one word per cycle while the output is not stalled; each of
// the two scaling units takes a new word every cycle (square root and
// division one bit per stage).
// A stalled output word freezes the whole pipeline until it is taken.
// Reset (rst_ni low, asynchronous) clears all valid bits; no data is reset.
`default_nettype none

module axes_to_quaternion
  import aq_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [IN_W-1:0] x_axis_x_i,
  input  logic signed [IN_W-1:0] x_axis_y_i,
  input  logic signed [IN_W-1:0] x_axis_z_i,
  input  logic signed [IN_W-1:0] z_axis_x_i,
  input  logic signed [IN_W-1:0] z_axis_y_i,
  input  logic signed [IN_W-1:0] z_axis_z_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [IN_W-1:0] quat_1_o,
  output logic signed [IN_W-1:0] quat_2_o,
  output logic signed [IN_W-1:0] quat_3_o,
  output logic signed [IN_W-1:0] quat_4_o,
  output logic [1:0]             branch_used_o
);

  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // stage 1: z cross x products
  logic                     t1_vld_q;
  logic signed [WIDE_W-1:0] t1_p_q [6];
  vec3_t                    t1_az_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_vld_q <= 1'b0;
    end else if (en) begin
      t1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_p_q[0] <= z_axis_y_i * x_axis_z_i;
      t1_p_q[1] <= z_axis_z_i * x_axis_y_i;
      t1_p_q[2] <= z_axis_z_i * x_axis_x_i;
      t1_p_q[3] <= z_axis_x_i * x_axis_z_i;
      t1_p_q[4] <= z_axis_x_i * x_axis_y_i;
      t1_p_q[5] <= z_axis_y_i * x_axis_x_i;
      t1_az_q   <= {z_axis_z_i, z_axis_y_i, z_axis_x_i};
    end
  end

  // stage 2: halved differences
  logic                     t2_vld_q;
  logic signed [WIDE_W-1:0] yr_q [3];
  vec3_t                    t2_az_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t2_vld_q <= 1'b0;
    end else if (en) begin
      t2_vld_q <= t1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        yr_q[i] <= (t1_p_q[2*i] >>> 1) - (t1_p_q[2*i+1] >>> 1);
      end
      t2_az_q <= t1_az_q;
    end
  end

  // unit y axis
  logic                   u1_vld;
  logic signed [IN_W-1:0] ay [3];
  vec3_t                  u1_az;

  aq_unit #(
    .N      (3),
    .W      (WIDE_W),
    .SIDE_W (3 * IN_W)
  ) u_unit_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (t2_vld_q),
    .v_i     (yr_q),
    .side_i  (t2_az_q),
    .valid_o (u1_vld),
    .u_o     (ay),
    .side_o  (u1_az)
  );

  // stage 3: y cross z products
  logic                     t3_vld_q;
  logic signed [WIDE_W-1:0] t3_p_q  [6];
  logic signed [IN_W-1:0]   t3_ay_q [3];
  vec3_t                    t3_az_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t3_vld_q <= 1'b0;
    end else if (en) begin
      t3_vld_q <= u1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t3_p_q[0] <= ay[1] * $signed(u1_az[2]);
      t3_p_q[1] <= ay[2] * $signed(u1_az[1]);
      t3_p_q[2] <= ay[2] * $signed(u1_az[0]);
      t3_p_q[3] <= ay[0] * $signed(u1_az[2]);
      t3_p_q[4] <= ay[0] * $signed(u1_az[1]);
      t3_p_q[5] <= ay[1] * $signed(u1_az[0]);
      t3_ay_q   <= ay;
      t3_az_q   <= u1_az;
    end
  end

  // stage 4: rounded rebuilt x axis
  logic                     t4_vld_q;
  logic signed [WIDE_W-1:0] bx_wide [3];
  logic signed [BX_W-1:0]   bx_q    [3];
  logic signed [IN_W-1:0]   t4_ay_q [3];
  vec3_t                    t4_az_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      bx_wide[i] = (t3_p_q[2*i] - t3_p_q[2*i+1] + HALF_FX) >>> FRAC_BITS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t4_vld_q <= 1'b0;
    end else if (en) begin
      t4_vld_q <= t3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        bx_q[i] <= BX_W'(bx_wide[i]);
      end
      t4_ay_q <= t3_ay_q;
      t4_az_q <= t3_az_q;
    end
  end

  // stage 5: trace test and raw quaternion
  logic                  t5_vld_q;
  logic signed [Q_W-1:0] bq [3];
  logic signed [Q_W-1:0] yq [3];
  logic signed [Q_W-1:0] zq [3];
  logic signed [Q_W-1:0] tr;
  logic signed [Q_W-1:0] q_d [4];
  logic signed [Q_W-1:0] q_q [4];
  branch_e               br_d;
  branch_e               br_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      bq[i] = Q_W'(bx_q[i]);
      yq[i] = Q_W'(t4_ay_q[i]);
      zq[i] = Q_W'($signed(t4_az_q[i]));
    end
    tr = ONE_Q + bq[0] + yq[1] + zq[2];
    priority if (tr > TRACE_MIN_Q) begin
      br_d   = BR_TRACE;
      q_d[0] = yq[2] - zq[1];
      q_d[1] = zq[0] - bq[2];
      q_d[2] = bq[1] - yq[0];
      q_d[3] = tr;
    end else if (bq[0] >= yq[1] && bq[0] >= zq[2]) begin
      br_d   = BR_X;
      q_d[0] = ONE_Q + bq[0] - yq[1] - zq[2];
      q_d[1] = yq[0] + bq[1];
      q_d[2] = zq[0] + bq[2];
      q_d[3] = yq[2] - zq[1];
    end else if (yq[1] >= bq[0] && yq[1] >= zq[2]) begin
      br_d   = BR_Y;
      q_d[0] = yq[0] + bq[1];
      q_d[1] = ONE_Q - bq[0] + yq[1] - zq[2];
      q_d[2] = zq[1] + yq[2];
      q_d[3] = zq[0] - bq[2];
    end else begin
      br_d   = BR_Z;
      q_d[0] = zq[0] + bq[2];
      q_d[1] = zq[1] + yq[2];
      q_d[2] = ONE_Q - bq[0] - yq[1] + zq[2];
      q_d[3] = bq[1] - yq[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t5_vld_q <= 1'b0;
    end else if (en) begin
      t5_vld_q <= t4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q_q  <= q_d;
      br_q <= br_d;
    end
  end

  // unit quaternion
  logic signed [IN_W-1:0] uq [4];
  logic [1:0]             br_out;

  aq_unit #(
    .N      (4),
    .W      (Q_W),
    .SIDE_W (2)
  ) u_unit_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (t5_vld_q),
    .v_i     (q_q),
    .side_i  (br_q),
    .valid_o (out_valid_o),
    .u_o     (uq),
    .side_o  (br_out)
  );

  assign quat_1_o      = uq[0];
  assign quat_2_o      = uq[1];
  assign quat_3_o      = uq[2];
  assign quat_4_o      = uq[3];
  assign branch_used_o = br_out;

endmodule

`default_nettype wire

/* rtl/core/aq_unit.sv */
`default_nettype none

// Pipelined unit-length scaling: block-shift to 30 bits, sum of squares,
// bit-per-stage square root, bit-per-stage restoring division per lane.
module aq_unit
  import aq_pkg::*;
#(
  parameter int N      = 3,
  parameter int W      = 64,
  parameter int SIDE_W = 96
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic signed [W-1:0]      v_i [N],
  input  logic [SIDE_W-1:0]        side_i,
  output logic                     valid_o,
  output logic signed [IN_W-1:0]   u_o [N],
  output logic [SIDE_W-1:0]        side_o
);

  localparam int SH_W      = $clog2(W + 1);
  localparam int DIV_STEPS = QUO_BITS;
  localparam int LAT       = 4 + ROOT_STEPS + 1 + DIV_STEPS + 1;

  // valid and side data travel in a plain chain beside the stages
  logic [LAT-1:0]    vld_q;
  logic [SIDE_W-1:0] side_q [LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int k = 1; k < LAT; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign valid_o = vld_q[LAT-1];
  assign side_o  = side_q[LAT-1];

  // stage 1: largest magnitude and block shift
  logic [W-1:0]        mag_in [N];
  logic [W-1:0]        max_mag;
  logic [SH_W-1:0]     bl;
  logic [SH_W-1:0]     sh_d;
  logic signed [W-1:0] s1_v_q [N];
  logic [SH_W-1:0]     s1_sh_q;

  always_comb begin
    max_mag = '0;
    for (int i = 0; i < N; i++) begin
      mag_in[i] = v_i[i][W-1] ? $unsigned(-v_i[i]) : $unsigned(v_i[i]);
      if (mag_in[i] > max_mag) begin
        max_mag = mag_in[i];
      end
    end
    bl = '0;
    for (int b = 0; b < W; b++) begin
      if (max_mag[b]) begin
        bl = SH_W'(b + 1);
      end
    end
    sh_d = (bl > SH_W'(MANT_BITS)) ? bl - SH_W'(MANT_BITS) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_v_q  <= v_i;
      s1_sh_q <= sh_d;
    end
  end

  // stage 2: shifted components as sign and magnitude
  logic signed [W-1:0]          w_d [N];
  logic [N-1:0]                 s2_sgn_q;
  logic [N-1:0][MAG_W-1:0]      s2_mag_q;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      w_d[i] = s1_v_q[i] >>> s1_sh_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < N; i++) begin
        s2_sgn_q[i] <= w_d[i][W-1];
        s2_mag_q[i] <= w_d[i][W-1] ? MAG_W'(-w_d[i]) : MAG_W'(w_d[i]);
      end
    end
  end

  // stage 3: squares
  logic [2*MAG_W-1:0]      s3_sq_q [N];
  logic [N-1:0]            s3_sgn_q;
  logic [N-1:0][MAG_W-1:0] s3_mag_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < N; i++) begin
        s3_sq_q[i] <= s2_mag_q[i] * s2_mag_q[i];
      end
      s3_sgn_q <= s2_sgn_q;
      s3_mag_q <= s2_mag_q;
    end
  end

  // stage 4: sum of squares
  logic [SUM_W-1:0]        sum_d;
  logic [SUM_W-1:0]        s4_sum_q;
  logic [N-1:0]            s4_sgn_q;
  logic [N-1:0][MAG_W-1:0] s4_mag_q;

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < N; i++) begin
      sum_d = sum_d + SUM_W'(s3_sq_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_sum_q <= sum_d;
      s4_sgn_q <= s3_sgn_q;
      s4_mag_q <= s3_mag_q;
    end
  end

  // square root, one result bit per stage
  logic [SUM_W-1:0]        rt_a_q   [ROOT_STEPS];
  logic [SUM_W-1:0]        rt_r_q   [ROOT_STEPS];
  logic [N-1:0]            rt_sgn_q [ROOT_STEPS];
  logic [N-1:0][MAG_W-1:0] rt_mag_q [ROOT_STEPS];

  for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
    localparam int BP = 2 * (ROOT_STEPS - 1 - j);
    logic [SUM_W-1:0]        a_in;
    logic [SUM_W-1:0]        r_in;
    logic [SUM_W-1:0]        t;
    logic [SUM_W-1:0]        bitv;
    logic [N-1:0]            sgn_in;
    logic [N-1:0][MAG_W-1:0] mag_in_r;

    if (j == 0) begin : g_first
      assign a_in     = s4_sum_q;
      assign r_in     = '0;
      assign sgn_in   = s4_sgn_q;
      assign mag_in_r = s4_mag_q;
    end else begin : g_next
      assign a_in     = rt_a_q[j-1];
      assign r_in     = rt_r_q[j-1];
      assign sgn_in   = rt_sgn_q[j-1];
      assign mag_in_r = rt_mag_q[j-1];
    end

    assign bitv = SUM_W'(1) << BP;
    assign t    = r_in + bitv;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (a_in >= t) begin
          rt_a_q[j] <= a_in - t;
          rt_r_q[j] <= (r_in >> 1) + bitv;
        end else begin
          rt_a_q[j] <= a_in;
          rt_r_q[j] <= r_in >> 1;
        end
        rt_sgn_q[j] <= sgn_in;
        rt_mag_q[j] <= mag_in_r;
      end
    end
  end

  // divider setup: numerator |w| * 2^F + n/2, zero norm divides by one
  logic [ROOT_W-1:0]       n_d;
  logic [ROOT_W-1:0]       pr_n_q;
  logic [N-1:0]            pr_sgn_q;
  logic [N-1:0][REM_W-1:0] pr_rem_q;

  always_comb begin
    n_d = rt_r_q[ROOT_STEPS-1][ROOT_W-1:0];
    if (n_d == '0) begin
      n_d = ROOT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < N; i++) begin
        pr_rem_q[i] <= (REM_W'(rt_mag_q[ROOT_STEPS-1][i]) << FRAC_BITS)
                       + REM_W'(n_d >> 1);
      end
      pr_n_q   <= n_d;
      pr_sgn_q <= rt_sgn_q[ROOT_STEPS-1];
    end
  end

  // restoring division, one quotient bit per stage
  logic [N-1:0][REM_W-1:0]    dv_rem_q [DIV_STEPS];
  logic [N-1:0][QUO_BITS-1:0] dv_quo_q [DIV_STEPS];
  logic [ROOT_W-1:0]          dv_n_q   [DIV_STEPS];
  logic [N-1:0]               dv_sgn_q [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    localparam int BQ = QUO_BITS - 1 - k;
    logic [N-1:0][REM_W-1:0]    rem_in;
    logic [N-1:0][QUO_BITS-1:0] quo_in;
    logic [ROOT_W-1:0]          n_in;
    logic [N-1:0]               sgn_in;
    logic [REM_W-1:0]           dsub;

    if (k == 0) begin : g_first
      assign rem_in = pr_rem_q;
      assign quo_in = '0;
      assign n_in   = pr_n_q;
      assign sgn_in = pr_sgn_q;
    end else begin : g_next
      assign rem_in = dv_rem_q[k-1];
      assign quo_in = dv_quo_q[k-1];
      assign n_in   = dv_n_q[k-1];
      assign sgn_in = dv_sgn_q[k-1];
    end

    assign dsub = REM_W'(n_in) << BQ;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int i = 0; i < N; i++) begin
          if (rem_in[i] >= dsub) begin
            dv_rem_q[k][i] <= rem_in[i] - dsub;
            dv_quo_q[k][i] <= quo_in[i] | (QUO_BITS'(1) << BQ);
          end else begin
            dv_rem_q[k][i] <= rem_in[i];
            dv_quo_q[k][i] <= quo_in[i];
          end
        end
        dv_n_q[k]   <= n_in;
        dv_sgn_q[k] <= sgn_in;
      end
    end
  end

  // output: restore sign
  logic signed [IN_W-1:0] uq_d [N];
  logic signed [IN_W-1:0] u_q  [N];

  always_comb begin
    for (int i = 0; i < N; i++) begin
      uq_d[i] = $signed(IN_W'(dv_quo_q[DIV_STEPS-1][i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < N; i++) begin
        u_q[i] <= dv_sgn_q[DIV_STEPS-1][i] ? -uq_d[i] : uq_d[i];
      end
    end
  end

  assign u_o = u_q;

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import aq_pkg::*;

  typedef struct {
    logic signed [31:0] q1, q2, q3, q4;
    branch_e            br;
  } quat_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [IN_W-1:0] x_axis_x_i = '0, x_axis_y_i = '0, x_axis_z_i = '0;
  logic signed [IN_W-1:0] z_axis_x_i = '0, z_axis_y_i = '0, z_axis_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [IN_W-1:0] quat_1_o, quat_2_o, quat_3_o, quat_4_o;
  logic [1:0] branch_used_o;

  quat_word_t expected_quats[$];
  int errors = 0;
  int sent = 0;
  int got = 0;
  int branch_seen[4] = '{0, 0, 0, 0};
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_cnt = 0;

  localparam longint ONE = 64'sd1 << FRAC_BITS;
  localparam longint THRESH = ((64'sd1 << FRAC_BITS) + 50) / 100;

  axes_to_quaternion DUT (.*);

  always #5 clk_i = ~clk_i;

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned a);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > a) b = b >> 2;
    while (b != 0) begin
      if (a >= r + b) begin
        a = a - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // scale k components to unit length; all-zero input stays zero
  function automatic void normalize(input longint v[4], input int k, output longint o[4]);
    longint unsigned m, ss, n, a;
    longint w[4];
    int bl, s;
    m = 0;
    ss = 0;
    o = '{0, 0, 0, 0};
    for (int i = 0; i < k; i++) if (mag(v[i]) > m) m = mag(v[i]);
    if (m == 0) return;
    bl = 0;
    while ((m >> bl) != 0) bl++;
    s = bl > MANT_BITS ? bl - MANT_BITS : 0;
    for (int i = 0; i < k; i++) begin
      w[i] = v[i] >>> s;
      ss += mag(w[i]) * mag(w[i]);
    end
    n = int_sqrt(ss);
    if (n == 0) n = 1;
    for (int i = 0; i < k; i++) begin
      a = ((mag(w[i]) << FRAC_BITS) + n / 2) / n;
      o[i] = w[i] < 0 ? -longint'(a) : longint'(a);
    end
  endfunction

  function automatic quat_word_t predict_quat(input logic signed [31:0] f[6]);
    longint ax[3], az[3], yr[4], ay[4], bx[3], q[4], u[4], tr;
    quat_word_t r;
    for (int i = 0; i < 3; i++) begin
      ax[i] = f[i];
      az[i] = f[3+i];
    end
    yr[0] = ((az[1] * ax[2]) >>> 1) - ((az[2] * ax[1]) >>> 1);
    yr[1] = ((az[2] * ax[0]) >>> 1) - ((az[0] * ax[2]) >>> 1);
    yr[2] = ((az[0] * ax[1]) >>> 1) - ((az[1] * ax[0]) >>> 1);
    yr[3] = 0;
    normalize(yr, 3, ay);
    bx[0] = (ay[1] * az[2] - ay[2] * az[1] + (ONE >>> 1)) >>> FRAC_BITS;
    bx[1] = (ay[2] * az[0] - ay[0] * az[2] + (ONE >>> 1)) >>> FRAC_BITS;
    bx[2] = (ay[0] * az[1] - ay[1] * az[0] + (ONE >>> 1)) >>> FRAC_BITS;
    tr = ONE + bx[0] + ay[1] + az[2];
    if (tr > THRESH) begin
      r.br = BR_TRACE;
      q = '{ay[2] - az[1], az[0] - bx[2], bx[1] - ay[0], tr};
    end else if (bx[0] >= ay[1] && bx[0] >= az[2]) begin
      r.br = BR_X;
      q = '{ONE + bx[0] - ay[1] - az[2], ay[0] + bx[1], az[0] + bx[2], ay[2] - az[1]};
    end else if (ay[1] >= bx[0] && ay[1] >= az[2]) begin
      r.br = BR_Y;
      q = '{ay[0] + bx[1], ONE - bx[0] + ay[1] - az[2], az[1] + ay[2], az[0] - bx[2]};
    end else begin
      r.br = BR_Z;
      q = '{az[0] + bx[2], az[1] + ay[2], ONE - bx[0] - ay[1] + az[2], bx[1] - ay[0]};
    end
    normalize(q, 4, u);
    r.q1 = u[0][31:0];
    r.q2 = u[1][31:0];
    r.q3 = u[2][31:0];
    r.q4 = u[3][31:0];
    return r;
  endfunction

  // called right after a rising edge; returns right after the accepting edge
  task automatic send_axes(input logic signed [31:0] f[6]);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    x_axis_x_i <= f[0];
    x_axis_y_i <= f[1];
    x_axis_z_i <= f[2];
    z_axis_x_i <= f[3];
    z_axis_y_i <= f[4];
    z_axis_z_i <= f[5];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_quats.push_back(predict_quat(f));
    sent++;
  endtask

  task automatic idle_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] near_unit(int kind);
    longint v;
    case (kind)
      0: v = longint'($urandom_range(0, 32'h8000_0000)) - ONE;
      1: v = $signed($urandom());
      default: v = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
    endcase
    return v[31:0];
  endfunction

  // signed-permutation axes plus small noise reach the non-trace branches
  function automatic void rand_axes(output logic signed [31:0] f[6]);
    int pick, ix, iz;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      ix = $urandom_range(0, 2);
      iz = (ix + $urandom_range(1, 2)) % 3;
      for (int i = 0; i < 6; i++) f[i] = near_unit(2);
      f[ix] = f[ix] + 32'($urandom_range(0, 1) ? ONE : -ONE);
      f[3+iz] = f[3+iz] + 32'($urandom_range(0, 1) ? ONE : -ONE);
    end else begin
      for (int i = 0; i < 6; i++) f[i] = near_unit(pick == 9 ? 1 : 0);
    end
  endfunction

  always @(posedge clk_i) begin
    if (hold_req > 0) begin
      hold_cnt <= hold_req;
      hold_req = 0;
      out_stall_i <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    quat_word_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got++;
      if (expected_quats.size() == 0) begin
        $display("%0t: unexpected word q=%h %h %h %h br=%0d", $time,
                 quat_1_o, quat_2_o, quat_3_o, quat_4_o, branch_used_o);
        errors++;
      end else begin
        e = expected_quats.pop_front();
        branch_seen[e.br]++;
        if (quat_1_o !== e.q1 || quat_2_o !== e.q2 || quat_3_o !== e.q3 ||
            quat_4_o !== e.q4 || branch_used_o !== e.br) begin
          $display("%0t: mismatch expected q=%h %h %h %h br=%0d actual q=%h %h %h %h br=%0d",
                   $time, e.q1, e.q2, e.q3, e.q4, e.br,
                   quat_1_o, quat_2_o, quat_3_o, quat_4_o, branch_used_o);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    logic signed [31:0] d[6];
    longint o;
    o = ONE;
    d = '{o[31:0], 0, 0, 0, 0, o[31:0]};           send_axes(d); // identity
    d = '{o[31:0], 0, 0, 0, 0, -o[31:0]};          send_axes(d); // x largest
    d = '{-o[31:0], 0, 0, 0, 0, -o[31:0]};         send_axes(d); // y largest
    d = '{-o[31:0], 0, 0, 0, 0, o[31:0]};          send_axes(d); // z largest
    d = '{0, o[31:0], 0, 0, 0, o[31:0]};           send_axes(d);
    d = '{0, 0, 0, 0, 0, 0};                       send_axes(d); // zero axes
    d = '{o[31:0], 0, 0, o[31:0], 0, 0};           send_axes(d); // parallel
    d = '{o[31:0], 0, 0, -o[31:0], 0, 0};          send_axes(d); // antiparallel
    d = '{0, 0, o[31:0], 0, 0, 0};                 send_axes(d); // zero z
    d = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
          32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000}; send_axes(d);
    d = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
          32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff}; send_axes(d);
    d = '{-1, -1, -1, -1, -1, -1};                 send_axes(d);
    d = '{1, 0, 0, 0, 0, 1};                       send_axes(d); // tiny
    d = '{32'sh7fff_ffff, 0, 0, 0, 0, 32'sh8000_0000}; send_axes(d);
    d = '{o[31:0], o[31:0], 0, 0, 0, o[31:0]};     send_axes(d); // non-unit x
    d = '{0, o[31:0], 0, 0, 0, -o[31:0]};          send_axes(d);
    d = '{0, -o[31:0], 0, 0, 0, -o[31:0]};         send_axes(d);
    d = '{0, 0, o[31:0], o[31:0], 0, 0};           send_axes(d);
    idle_input();
  endtask

  task automatic test_random(int n, int idle_pct, int stall);
    logic signed [31:0] d[6];
    send_idle_pct = idle_pct;
    stall_pct = stall;
    repeat (n) begin
      rand_axes(d);
      send_axes(d);
    end
    idle_input();
  endtask

  // long receiver hold-off while the input keeps offering words
  task automatic test_backpressure();
    logic signed [31:0] d[6];
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 400;
    repeat (200) begin
      rand_axes(d);
      send_axes(d);
    end
    idle_input();
  endtask

  task automatic test_drain_pause();
    while (expected_quats.size() != 0) @(posedge clk_i);
    test_random(20, 0, 0);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(200, 0, 0);
    test_random(200, 56, 0);
    test_random(200, 0, 56);
    test_random(200, 17, 17);
    test_backpressure();
    test_drain_pause();
    stall_pct = 0;
    while (expected_quats.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d axis words, checked %0d quaternions.", sent, got);
    $display("Branches: trace %0d, x %0d, y %0d, z %0d.",
             branch_seen[0], branch_seen[1], branch_seen[2], branch_seen[3]);
    if (errors == 0) begin
      $display("** axes_to_quaternion: PASSED **");
    end else begin
      $display("** axes_to_quaternion: FAILED **");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d words outstanding.", expected_quats.size());
    $display("** axes_to_quaternion: FAILED **");
    $finish;
  end

endmodule

/* files.f */
rtl/core/aq_pkg.sv
rtl/core/aq_unit.sv
rtl/core/axes_to_quaternion.sv
tb/sv/testbench.sv
